[sv/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and codes for the byte stack: payload beats, command kinds,
// status codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // Stack geometry
    localparam int DEPTH  = 64;
    localparam int FILL_W = 7;
    localparam int KIND_W = 3;
    localparam int ST_W   = 2;
    localparam int OP_W   = 3;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DUP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UROT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DROT = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DUMP = 3'd6;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

    // Cell chain operations
    localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd1;
    localparam logic [OP_W-1:0] OP_POP      = 3'd2;
    localparam logic [OP_W-1:0] OP_DUP      = 3'd3;
    localparam logic [OP_W-1:0] OP_ROT_ITEM = 3'd4;
    localparam logic [OP_W-1:0] OP_ROT_FILL = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        push_byte;
        logic [FILL_W-1:0] rotate_span;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [7:0]      data_byte;
        logic            has_data;
        logic            last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic              load_item;
        logic [OP_W-1:0]   op;
        logic              emit;
        logic [ST_W-1:0]   emit_status;
        logic              emit_data;
        logic              emit_last_cnt;
        logic              cnt_load_span;
        logic              cnt_load_fill;
        logic              cnt_dec;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              rot_ok;
        logic              out_free;
        logic              cnt_last;
    } t_stat;

endpackage

[sv/byte_stack_with_rotate.sv]
// ----------------------------------------------------------------------------
// byte_stack_with_rotate
// Byte-wide stack with push, pop, peek, duplicate, up/down rotate and dump.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Beat
//  in        to block   i_in_valid / o_in_stall       t_in_item (one command)
//  out       from block o_out_valid / i_out_stall     t_out_item (one result)
//  cfg       to block   i_cfg_wr_en                   capacity_in_use, 7 bits
//
//  Push, pop, peek, duplicate, up-rotate and ignored commands are accepted,
//  then executed into the output register.
//  Down-rotate: result, then one up-rotate pass of the cell chain a cycle.
//  Dump: one byte a cycle out of the top cell while the output is free.
//  Output stall holds the result register and delays the execute step.
//  Synchronous reset empties the stack and sets the capacity to 64.
// ----------------------------------------------------------------------------
module byte_stack_with_rotate import bsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [FILL_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    bsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Cell chain and result register
    bsr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

[sv/bsr_ctrl.sv]
// ----------------------------------------------------------------------------
// bsr_ctrl
// Sequencer for the byte stack: takes one command beat, executes it against
// the datapath, and steps through down-rotate passes and dump beats.
// ----------------------------------------------------------------------------
module bsr_ctrl import bsr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ROTD = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Accept only when idle and out of reset
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

    // Decode state and status into datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    n_state           = S_IDLE;
                    unique case (i_stat.kind)
                        KIND_PUSH: begin
                            if (i_stat.full) o_cmd.emit_status = ST_FULL;
                            else             o_cmd.op          = OP_PUSH;
                        end
                        KIND_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.op        = OP_POP;
                                o_cmd.emit_data = 1'b1;
                            end
                        end
                        KIND_PEEK: begin
                            if (i_stat.empty) o_cmd.emit_status = ST_EMPTY;
                            else              o_cmd.emit_data   = 1'b1;
                        end
                        KIND_DUP: begin
                            if (i_stat.empty)     o_cmd.emit_status = ST_EMPTY;
                            else if (i_stat.full) o_cmd.emit_status = ST_FULL;
                            else                  o_cmd.op          = OP_DUP;
                        end
                        KIND_UROT: begin
                            if (i_stat.rot_ok) o_cmd.op          = OP_ROT_ITEM;
                            else               o_cmd.emit_status = ST_IGNORED;
                        end
                        KIND_DROT: begin
                            // Report now, then run span-1 up-rotate passes
                            if (i_stat.rot_ok) begin
                                o_cmd.cnt_load_span = 1'b1;
                                n_state             = S_ROTD;
                            end else begin
                                o_cmd.emit_status = ST_IGNORED;
                            end
                        end
                        KIND_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.emit_status = ST_EMPTY;
                            end else begin
                                o_cmd.emit          = 1'b0;
                                o_cmd.cnt_load_fill = 1'b1;
                                n_state             = S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.emit_status = ST_OK;
                        end
                    endcase
                end
            end
            S_ROTD: begin
                o_cmd.op      = OP_ROT_ITEM;
                o_cmd.cnt_dec = 1'b1;
                if (i_stat.cnt_last) n_state = S_IDLE;
            end
            S_DUMP: begin
                // Emit top, then rotate the whole stack one place
                if (i_stat.out_free) begin
                    o_cmd.emit          = 1'b1;
                    o_cmd.emit_status   = ST_OK;
                    o_cmd.emit_data     = 1'b1;
                    o_cmd.emit_last_cnt = 1'b1;
                    o_cmd.op            = OP_ROT_FILL;
                    o_cmd.cnt_dec       = 1'b1;
                    if (i_stat.cnt_last) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/bsr_dpath.sv]
// ----------------------------------------------------------------------------
// bsr_dpath
// Datapath for the byte stack: a chain of byte cells with the top in cell 0,
// fill level, capacity register, command register, pass counter and the
// output register.
// ----------------------------------------------------------------------------
module bsr_dpath import bsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [FILL_W-1:0] i_cfg_wr_data,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat
);

    logic [7:0]        r_cell [DEPTH];
    logic [7:0]        n_cell [DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] r_cap;
    logic [FILL_W-1:0] r_cnt;
    t_in_item          r_item;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic [FILL_W-1:0] eff_cap;
    logic [FILL_W-1:0] rot_span;
    logic [FILL_W-1:0] rot_sm1;
    logic              cnt_last;
    logic              out_free;

    // Status toward the controller
    assign eff_cap  = (r_cap > FILL_W'(DEPTH)) ? FILL_W'(DEPTH) : r_cap;
    assign cnt_last = (r_cnt == FILL_W'(1));
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.kind     = r_item.kind;
    assign o_stat.empty    = (r_fill == '0);
    assign o_stat.full     = (r_fill >= eff_cap);
    assign o_stat.rot_ok   = (r_item.rotate_span > FILL_W'(1)) &&
                             (r_item.rotate_span <= r_fill);
    assign o_stat.out_free = out_free;
    assign o_stat.cnt_last = cnt_last;

    // Up-rotate span: command span, or the whole stack during dump
    assign rot_span = (i_cmd.op == OP_ROT_FILL) ? r_fill : r_item.rotate_span;
    assign rot_sm1  = rot_span - FILL_W'(1);

    // Per-cell next value
    always_comb begin
        n_cell = r_cell;
        n_fill = r_fill;
        unique case (i_cmd.op) inside
            OP_PUSH: begin
                for (int i = 1; i < DEPTH; i++) n_cell[i] = r_cell[i-1];
                n_cell[0] = r_item.push_byte;
                n_fill    = r_fill + FILL_W'(1);
            end
            OP_DUP: begin
                for (int i = 1; i < DEPTH; i++) n_cell[i] = r_cell[i-1];
                n_fill = r_fill + FILL_W'(1);
            end
            OP_POP: begin
                for (int i = 0; i < DEPTH - 1; i++) n_cell[i] = r_cell[i+1];
                n_fill = r_fill - FILL_W'(1);
            end
            OP_ROT_ITEM, OP_ROT_FILL: begin
                // Cells above the span's bottom move up, old top drops there
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (FILL_W'(i) < rot_sm1) n_cell[i] = r_cell[i+1];
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (FILL_W'(i) == rot_sm1) n_cell[i] = r_cell[0];
                end
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    // Build the result beat
    always_comb begin
        n_out.status    = i_cmd.emit_status;
        n_out.data_byte = i_cmd.emit_data ? r_cell[0] : 8'd0;
        n_out.has_data  = i_cmd.emit_data;
        n_out.last      = i_cmd.emit_last_cnt ? cnt_last : 1'b1;
    end

    // Hold cells and command; no reset on payload
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (i_cmd.load_item) r_item <= i_in_data;
        if (i_cmd.emit)      r_out  <= n_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= FILL_W'(DEPTH);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (i_cmd.cnt_load_span) begin
                r_cnt <= r_item.rotate_span - FILL_W'(1);
            end else if (i_cmd.cnt_load_fill) begin
                r_cnt <= r_fill;
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - FILL_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/bsr_checker.sv]
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks for the byte stack, bound to the top level.
// ----------------------------------------------------------------------------
module bsr_checker import bsr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_wr_en,
    input logic [FILL_W-1:0] i_cfg_wr_data,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input t_in_item          i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_data
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed under stall");

    // One command at a time: stall right after an accepted beat
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command accepted while busy");

    // Reset clears the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Results without a byte carry zero
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.has_data) |-> (o_out_data.data_byte == 8'd0))
        else $error("nonzero byte without data");

    // Error status ends the command and carries no byte
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |->
        (o_out_data.last && !o_out_data.has_data))
        else $error("error result not final");

endmodule

bind byte_stack_with_rotate bsr_checker u_bsr_checker (.*);

[tb/sv/bsr_stack_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_stack_check
// Watches the command, result and configuration ports of the byte stack. It
// keeps its own copy of the stack contents, fill level and capacity, works
// out the results each accepted command owes, and compares every result
// beat field by field with the oldest owed result.
// ----------------------------------------------------------------------------
module bsr_stack_check import bsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [FILL_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic [7:0]        stack_bytes [DEPTH];
    int                fill;
    logic [FILL_W-1:0] capacity;
    t_out_item         owed_results [$];
    int                beat_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        fill         = 0;
        capacity     = 7'd64;
        beat_count   = 0;
    end

    // Print one line per mismatch and count it
    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("beat %0d field %s got %0d want %0d",
                                    beat_count, name, got, want));
    endtask

    function automatic void owe_result(input logic [ST_W-1:0] status,
                                       input logic [7:0] data_byte,
                                       input logic has_data, input logic last);
        t_out_item r;
        r.status    = status;
        r.data_byte = data_byte;
        r.has_data  = has_data;
        r.last      = last;
        owed_results.push_back(r);
    endfunction

    // Update the stack copy for one command and queue the results it owes
    task automatic apply_command(input t_in_item cmd);
        int         limit;
        int         span;
        int         idx;
        logic [7:0] moved;
        limit = (capacity > DEPTH) ? DEPTH : int'(capacity);
        span  = int'(cmd.rotate_span);
        case (cmd.kind)
            KIND_PUSH: begin
                if (fill >= limit) begin
                    owe_result(ST_FULL, 8'd0, 1'b0, 1'b1);
                end else begin
                    stack_bytes[fill] = cmd.push_byte;
                    fill++;
                    owe_result(ST_OK, 8'd0, 1'b0, 1'b1);
                end
            end
            KIND_POP: begin
                if (fill == 0) begin
                    owe_result(ST_EMPTY, 8'd0, 1'b0, 1'b1);
                end else begin
                    fill--;
                    owe_result(ST_OK, stack_bytes[fill], 1'b1, 1'b1);
                end
            end
            KIND_PEEK: begin
                if (fill == 0)
                    owe_result(ST_EMPTY, 8'd0, 1'b0, 1'b1);
                else
                    owe_result(ST_OK, stack_bytes[fill-1], 1'b1, 1'b1);
            end
            KIND_DUP: begin
                // emptiness wins over full
                if (fill == 0) begin
                    owe_result(ST_EMPTY, 8'd0, 1'b0, 1'b1);
                end else if (fill >= limit) begin
                    owe_result(ST_FULL, 8'd0, 1'b0, 1'b1);
                end else begin
                    stack_bytes[fill] = stack_bytes[fill-1];
                    fill++;
                    owe_result(ST_OK, 8'd0, 1'b0, 1'b1);
                end
            end
            KIND_UROT, KIND_DROT: begin
                if (span <= 1 || span > fill) begin
                    owe_result(ST_IGNORED, 8'd0, 1'b0, 1'b1);
                end else if (cmd.kind == KIND_UROT) begin
                    // sink the top byte to depth span, lift the rest by one
                    moved = stack_bytes[fill-1];
                    for (idx = fill - 1; idx > fill - span; idx--)
                        stack_bytes[idx] = stack_bytes[idx-1];
                    stack_bytes[fill-span] = moved;
                    owe_result(ST_OK, 8'd0, 1'b0, 1'b1);
                end else begin
                    // raise the byte at depth span to the top, lower the rest
                    moved = stack_bytes[fill-span];
                    for (idx = fill - span; idx < fill - 1; idx++)
                        stack_bytes[idx] = stack_bytes[idx+1];
                    stack_bytes[fill-1] = moved;
                    owe_result(ST_OK, 8'd0, 1'b0, 1'b1);
                end
            end
            KIND_DUMP: begin
                if (fill == 0) begin
                    owe_result(ST_EMPTY, 8'd0, 1'b0, 1'b1);
                end else begin
                    for (idx = 0; idx < fill; idx++)
                        owe_result(ST_OK, stack_bytes[fill-1-idx], 1'b1,
                                   idx == fill - 1);
                end
            end
            default: owe_result(ST_OK, 8'd0, 1'b0, 1'b1);
        endcase
    endtask

    // Compare result beats first, then take config writes and commands
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            fill     = 0;
            capacity = 7'd64;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d arrived with nothing owed",
                                            beat_count));
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", int'(i_out_data.status),
                                int'(want.status));
                    check_field("data_byte", int'(i_out_data.data_byte),
                                int'(want.data_byte));
                    check_field("has_data", int'(i_out_data.has_data),
                                int'(want.has_data));
                    check_field("last", int'(i_out_data.last),
                                int'(want.last));
                end
                beat_count++;
            end
            if (i_cfg_wr_en)
                capacity = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                apply_command(i_in_data);
        end
        o_pending = owed_results.size();
    end

endmodule

[tb/sv/tb_byte_stack_with_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stack_with_rotate
// Drives commands into the byte stack: a directed pass over empty, full,
// ignored-rotate and dump cases, then random phases under several capacity
// settings (1, 64, 127, 0 and a random small one), with random input gaps
// and output stalls. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_byte_stack_with_rotate;
    import bsr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [FILL_W-1:0] cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_beat;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_beat;
    int                fail_count;
    int                pending;

    int cycles     = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int cap_guess  = 64;
    int depth_guess = 0;

    byte_stack_with_rotate dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_beat)
    );

    bsr_stack_check u_stack_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_beat),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // End the run if it hangs
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stall the result channel in bursts of random length
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Offer one command beat, with an optional gap, and hold until taken
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [7:0] data,
                           input logic [FILL_W-1:0] span);
        t_in_item cmd;
        cmd.kind        = kind;
        cmd.push_byte   = data;
        cmd.rotate_span = span;
        case (kind)
            KIND_PUSH: if (depth_guess < cap_guess) depth_guess++;
            KIND_POP:  if (depth_guess > 0) depth_guess--;
            KIND_DUP:  if (depth_guess > 0 && depth_guess < cap_guess) depth_guess++;
            default: ;
        endcase
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= cmd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every owed result is out and the block idles
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0 || in_stall);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [FILL_W-1:0] value);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_guess = (value > DEPTH) ? DEPTH : int'(value);
    endtask

    // Random commands; most rotates use a span that fits the current fill
    task automatic run_random(input int count, input int push_pct);
        logic [KIND_W-1:0] kind;
        logic [FILL_W-1:0] span;
        int                roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                kind = KIND_PUSH;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 20)      kind = KIND_POP;
                else if (roll < 32) kind = KIND_PEEK;
                else if (roll < 47) kind = KIND_DUP;
                else if (roll < 67) kind = KIND_UROT;
                else if (roll < 87) kind = KIND_DROT;
                else if (roll < 95) kind = KIND_DUMP;
                else                kind = KIND_SPARE;
            end
            span = FILL_W'($urandom_range(0, 127));
            if ((kind == KIND_UROT || kind == KIND_DROT) && $urandom_range(0, 9) < 7)
                span = FILL_W'($urandom_range(2, (depth_guess < 2) ? 2 : depth_guess));
            send_op(kind, 8'($urandom_range(0, 255)), span);
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        in_beat     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, byte extremes, rotates, dumps, spare kind
        write_capacity(7'd64);
        gap_pct   = 20;
        stall_pct = 20;
        send_op(KIND_POP,   8'h00, 7'd0);
        send_op(KIND_PEEK,  8'h00, 7'd0);
        send_op(KIND_DUP,   8'h00, 7'd0);
        send_op(KIND_DUMP,  8'h00, 7'd0);
        send_op(KIND_UROT,  8'h00, 7'd2);
        send_op(KIND_PUSH,  8'h00, 7'd0);
        send_op(KIND_PUSH,  8'hFF, 7'd0);
        send_op(KIND_PUSH,  8'hA5, 7'd0);
        send_op(KIND_PUSH,  8'h5A, 7'd0);
        send_op(KIND_PEEK,  8'h00, 7'd0);
        send_op(KIND_DUP,   8'h00, 7'd0);
        send_op(KIND_UROT,  8'h00, 7'd4);
        send_op(KIND_DUMP,  8'h00, 7'd0);
        send_op(KIND_DROT,  8'h00, 7'd4);
        send_op(KIND_UROT,  8'h00, 7'd1);
        send_op(KIND_DROT,  8'h00, 7'd0);
        send_op(KIND_UROT,  8'h00, 7'd127);
        send_op(KIND_DROT,  8'h00, 7'd5);
        send_op(KIND_UROT,  8'h00, 7'd5);
        send_op(KIND_SPARE, 8'hFF, 7'd127);
        send_op(KIND_POP,   8'h00, 7'd0);
        send_op(KIND_DUMP,  8'h00, 7'd0);

        // Capacity below the fill level: refuse pushes, keep contents
        write_capacity(7'd2);
        send_op(KIND_PUSH,  8'h3C, 7'd0);
        send_op(KIND_DUP,   8'h00, 7'd0);
        send_op(KIND_POP,   8'h00, 7'd0);
        send_op(KIND_POP,   8'h00, 7'd0);
        send_op(KIND_POP,   8'h00, 7'd0);
        send_op(KIND_PUSH,  8'hC3, 7'd0);
        send_op(KIND_PUSH,  8'h81, 7'd0);

        // Random phases over several capacities
        write_capacity(7'd64);
        gap_pct   = 15;
        stall_pct = 25;
        run_random(90, 50);

        write_capacity(7'd1);
        gap_pct   = 0;
        stall_pct = 0;
        run_random(25, 40);

        write_capacity(FILL_W'($urandom_range(3, 20)));
        gap_pct   = 40;
        stall_pct = 10;
        run_random(45, 45);

        write_capacity(7'd127);
        gap_pct   = 10;
        stall_pct = 40;
        run_random(45, 60);

        write_capacity(7'd0);
        gap_pct   = 25;
        stall_pct = 25;
        run_random(12, 40);

        // Last stretch runs without any idling
        gap_pct   = 0;
        stall_pct = 0;
        write_capacity(7'd64);
        run_random(25, 45);

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
